// ----- hdl/cbad_pkg.sv -----
// Shared types and constants for the CPU bus address decoder.
package cbad_pkg;

	typedef struct packed {
		logic        kind;
		logic        word_access;
		logic [23:0] address;
		logic [15:0] write_data;
		logic        sound_bus_held;
	} req_t;

	typedef struct packed {
		logic [3:0]  target;
		logic [21:0] local_addr;
		logic [1:0]  byte_lanes;
		logic [2:0]  device_place;
		logic [15:0] fill_value;
		logic [15:0] write_value;
		logic        lockup;
	} rsp_t;

	localparam logic KIND_READ  = 1'b0;
	localparam logic KIND_WRITE = 1'b1;

	localparam logic [3:0] TGT_NONE     = 4'd0;
	localparam logic [3:0] TGT_ROM      = 4'd1;
	localparam logic [3:0] TGT_WORKRAM  = 4'd2;
	localparam logic [3:0] TGT_SOUNDRAM = 4'd3;
	localparam logic [3:0] TGT_IO       = 4'd4;
	localparam logic [3:0] TGT_VDATA    = 4'd5;
	localparam logic [3:0] TGT_VCTRL    = 4'd6;
	localparam logic [3:0] TGT_VCOUNTER = 4'd7;
	localparam logic [3:0] TGT_ACKSTAT  = 4'd8;
	localparam logic [3:0] TGT_BUSREQ   = 4'd9;
	localparam logic [3:0] TGT_RESET    = 4'd10;
	localparam logic [3:0] TGT_BANK     = 4'd11;

	localparam logic [2:0] PLACE_NONE        = 3'd0;
	localparam logic [2:0] PLACE_WORD        = 3'd1;
	localparam logic [2:0] PLACE_HIGH_TO_LOW = 3'd2;
	localparam logic [2:0] PLACE_LOW_BYTE    = 3'd3;
	localparam logic [2:0] PLACE_BYTE_REP    = 3'd4;
	localparam logic [2:0] PLACE_LOW_TO_HIGH = 3'd5;

	localparam logic [15:0] OPEN_BUS_WORD = 16'h4E71;
	localparam logic [23:0] OPEN_BUS_HIGH = 24'hC00000;
	localparam logic [23:0] SOUND_LAST    = 24'hA0FFFF;
	localparam logic [23:0] IO_LAST       = 24'hA1001F;
	localparam logic [23:0] VDP_MASK      = 24'hE700E0;
	localparam logic [23:0] VDP_MATCH     = 24'hC00000;

endpackage

// ----- hdl/cpu_bus_address_decoder.sv -----
// Top level of the CPU bus address decoder: input register, decode and result register.
//
// The block takes one CPU bus transaction on the req channel (read or write, byte or
// word, 24-bit address, write data and the sound bus grant state) and returns one
// decoded transaction on the rsp channel: the target device, the local address,
// the byte lanes, how device read data is placed, the open-bus fill value, the
// prepared write value and the lockup flag for illegal regions.
// Both channels use valid and stall; a transaction moves at a rising edge where
// valid is high and stall is low.
// From acceptance on req to rsp_valid, the request is registered, decoded by a
// short block of logic, and the result is registered.
// Throughput is one transaction per cycle while rsp_stall is low; the decode
// has no state and no loop. When the receiver stalls, the result register holds. An empty input register still
// takes one more transaction; once both registers are full, req_stall follows
// rsp_stall in the same cycle, since it is formed from it combinationally.
// Reset (arst_n low, asynchronous) empties both stages; nothing else is cleared
// because the decode keeps no state between transactions.
module cpu_bus_address_decoder (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_stall,
	input  cbad_pkg::req_t  req,
	output logic            rsp_valid,
	input  logic            rsp_stall,
	output cbad_pkg::rsp_t  rsp
);

	logic            valid_s1;
	cbad_pkg::req_t  req_s1;
	logic            valid_s2;
	cbad_pkg::rsp_t  rsp_s2;
	cbad_pkg::rsp_t  rsp_dec;
	logic            hold_s2;
	logic            adv_s1;

	// The result stage holds while a finished transaction waits on the receiver.
	assign hold_s2   = valid_s2 && rsp_stall;
	// The input stage moves on whenever the result stage can take its contents.
	assign adv_s1    = !hold_s2;
	assign req_stall = valid_s1 && hold_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (!req_stall) begin
				valid_s1 <= req_valid;
			end
			if (adv_s1) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	// Payload registers load only with a live transaction and need no reset.
	always_ff @(posedge clk) begin
		if (req_valid && !req_stall) begin
			req_s1 <= req;
		end
		if (valid_s1 && adv_s1) begin
			rsp_s2 <= rsp_dec;
		end
	end

	cbad_decode u_decode (
		.req (req_s1),
		.rsp (rsp_dec)
	);

	assign rsp_valid = valid_s2;
	assign rsp       = rsp_s2;

`ifndef ASSERT_OFF
	// A transaction in the input stage with room ahead shows up as a result next cycle.
	a_advance: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !(valid_s2 && rsp_stall)) |=> rsp_valid)
		else $error("decoded transaction did not reach the result stage");

	// An illegal region never selects a device.
	a_lock_none: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.lockup) |-> (rsp.target == cbad_pkg::TGT_NONE))
		else $error("lockup raised together with a target");

	// Byte lanes are only given for the word memories.
	a_lanes: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.byte_lanes != 2'd0) |->
		(rsp.target == cbad_pkg::TGT_ROM || rsp.target == cbad_pkg::TGT_WORKRAM))
		else $error("byte lanes set for a target that is not ROM or work RAM");

	// Without a target there is nothing to write to.
	a_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.target == cbad_pkg::TGT_NONE) |-> (rsp.write_value == 16'h0000))
		else $error("write value prepared with no target");
`endif

endmodule

// ----- hdl/cbad_decode.sv -----
// Combinational decode of one bus transaction into target, lanes, placement and fill.
module cbad_decode (
	input  cbad_pkg::req_t req,
	output cbad_pkg::rsp_t rsp
);

	localparam logic [2:0] REG_ROM0  = 3'd0;
	localparam logic [2:0] REG_ROM1  = 3'd1;
	localparam logic [2:0] REG_OPEN0 = 3'd2;
	localparam logic [2:0] REG_OPEN1 = 3'd3;
	localparam logic [2:0] REG_ILLEG = 3'd4;
	localparam logic [2:0] REG_SOUND = 3'd5;
	localparam logic [2:0] REG_VDP   = 3'd6;
	localparam logic [2:0] REG_WRAM  = 3'd7;

	localparam logic [1:0] SND_RAM0 = 2'd0;
	localparam logic [1:0] SND_RAM1 = 2'd1;
	localparam logic [1:0] SND_GAP  = 2'd2;
	localparam logic [1:0] SND_CTRL = 2'd3;

	localparam logic [7:0] PAGE_IO     = 8'h00;
	localparam logic [7:0] PAGE_BUSREQ = 8'h11;
	localparam logic [7:0] PAGE_RESET  = 8'h12;
	localparam logic [7:0] PAGE_BANK   = 8'h60;
	localparam logic [7:0] PAGE_LOCK   = 8'h7F;

	logic        wd;
	logic [23:0] a;
	logic [1:0]  lm;
	logic [15:0] open_w;
	logic [15:0] openv;
	logic [15:0] ones;
	logic [7:0]  v8;
	logic        bit_v;
	logic [7:0]  sub;
	logic [4:0]  r;
	logic        quiet;
	logic        vdp_hit;
	logic        in_sound;
	logic        in_io;
	logic [7:0]  bank_page;

	always_comb begin
		wd       = req.word_access;
		a        = wd ? {req.address[23:1], 1'b0} : req.address;
		lm       = wd ? 2'b11 : (a[0] ? 2'b01 : 2'b10);
		open_w   = (a >= cbad_pkg::OPEN_BUS_HIGH) ? cbad_pkg::OPEN_BUS_WORD
			: {cbad_pkg::OPEN_BUS_WORD[15:8], 8'h00};
		openv    = wd ? open_w : (a[0] ? {8'h00, open_w[7:0]} : {8'h00, open_w[15:8]});
		ones     = wd ? 16'hFFFF : 16'h00FF;
		v8       = req.write_data[7:0];
		bit_v    = wd ? req.write_data[8] : req.write_data[0];
		sub      = a[15:8];
		r        = a[4:0];
		quiet    = (sub == 8'h10) || (sub == 8'h12) || (sub == 8'h13) ||
			(sub == 8'h20) || (sub == 8'h30);
		vdp_hit  = (a & cbad_pkg::VDP_MASK) == cbad_pkg::VDP_MATCH;
		in_sound = a <= cbad_pkg::SOUND_LAST;
		in_io    = a <= cbad_pkg::IO_LAST;
		// Word writes only see bits 14..8 when matching the bank page.
		bank_page = wd ? {1'b0, a[14:8]} : a[15:8];
		rsp      = '0;

		if (req.kind == cbad_pkg::KIND_READ) begin
			case (a[23:21])
				REG_ROM0, REG_ROM1: begin
					rsp.target     = cbad_pkg::TGT_ROM;
					rsp.local_addr = a[21:0];
					rsp.byte_lanes = lm;
				end
				REG_WRAM: begin
					rsp.target     = cbad_pkg::TGT_WORKRAM;
					rsp.local_addr = {6'd0, a[15:0]};
					rsp.byte_lanes = lm;
				end
				REG_OPEN0, REG_OPEN1: begin
					rsp.fill_value = openv;
				end
				REG_ILLEG: begin
					rsp.lockup     = 1'b1;
					rsp.fill_value = ones;
				end
				REG_SOUND: begin
					if (in_sound) begin
						if (req.sound_bus_held) begin
							rsp.fill_value = openv;
						end else begin
							case (a[14:13])
								SND_RAM0, SND_RAM1: begin
									rsp.target       = cbad_pkg::TGT_SOUNDRAM;
									rsp.local_addr   = {9'd0, a[12:0]};
									rsp.device_place = wd ? cbad_pkg::PLACE_BYTE_REP
										: cbad_pkg::PLACE_LOW_BYTE;
								end
								SND_GAP: begin
									rsp.fill_value = wd ? 16'hFFFF : 16'h0000;
								end
								default: begin
									rsp.lockup     = (a[15:8] == PAGE_LOCK);
									rsp.fill_value = ones;
								end
							endcase
						end
					end else if (!wd) begin
						if (sub == PAGE_IO && in_io) begin
							rsp.target       = cbad_pkg::TGT_IO;
							rsp.local_addr   = {18'd0, a[4:1]};
							rsp.device_place = cbad_pkg::PLACE_LOW_BYTE;
						end else if (sub == PAGE_BUSREQ && !a[0]) begin
							rsp.target       = cbad_pkg::TGT_ACKSTAT;
							rsp.device_place = cbad_pkg::PLACE_LOW_BYTE;
							rsp.fill_value   = openv & 16'h00FE;
						end else if (sub == PAGE_IO || sub == PAGE_BUSREQ || quiet) begin
							rsp.fill_value = openv;
						end else begin
							rsp.lockup     = 1'b1;
							rsp.fill_value = ones;
						end
					end else begin
						if (in_io) begin
							rsp.target       = cbad_pkg::TGT_IO;
							rsp.local_addr   = {18'd0, a[4:1]};
							rsp.device_place = cbad_pkg::PLACE_BYTE_REP;
						end else if (sub == PAGE_BUSREQ) begin
							rsp.target       = cbad_pkg::TGT_ACKSTAT;
							rsp.device_place = cbad_pkg::PLACE_LOW_TO_HIGH;
							rsp.fill_value   = openv & 16'hFEFF;
						end else if (quiet) begin
							rsp.fill_value = openv;
						end else begin
							rsp.lockup     = 1'b1;
							rsp.fill_value = ones;
						end
					end
				end
				default: begin
					if (!vdp_hit) begin
						rsp.lockup     = 1'b1;
						rsp.fill_value = ones;
					end else if (!r[4]) begin
						if (r[3:2] == 2'd0) begin
							rsp.target = cbad_pkg::TGT_VDATA;
						end else if (!r[3]) begin
							rsp.target = cbad_pkg::TGT_VCTRL;
							rsp.fill_value = wd ? (openv & 16'hFC00)
								: (a[0] ? 16'h0000 : (openv & 16'h00FC));
						end else begin
							rsp.target = cbad_pkg::TGT_VCOUNTER;
						end
						rsp.device_place = wd ? cbad_pkg::PLACE_WORD
							: (r[0] ? cbad_pkg::PLACE_LOW_BYTE : cbad_pkg::PLACE_HIGH_TO_LOW);
					end else if (!r[3]) begin
						rsp.lockup     = 1'b1;
						rsp.fill_value = ones;
					end else begin
						rsp.fill_value = openv;
					end
				end
			endcase
		end else begin
			case (a[23:21])
				REG_ROM0, REG_ROM1, REG_OPEN0, REG_OPEN1: begin
					rsp.target = cbad_pkg::TGT_NONE;
				end
				REG_ILLEG: begin
					rsp.lockup = 1'b1;
				end
				REG_WRAM: begin
					rsp.target      = cbad_pkg::TGT_WORKRAM;
					rsp.local_addr  = {6'd0, a[15:0]};
					rsp.byte_lanes  = lm;
					rsp.write_value = wd ? req.write_data : {v8, v8};
				end
				REG_VDP: begin
					if (!vdp_hit) begin
						rsp.lockup = 1'b1;
					end else if (r[4:3] == 2'd0) begin
						rsp.target      = r[2] ? cbad_pkg::TGT_VCTRL : cbad_pkg::TGT_VDATA;
						rsp.write_value = wd ? req.write_data : {v8, v8};
					end else if (!r[4]) begin
						rsp.lockup = 1'b1;
					end
				end
				default: begin
					if (in_sound) begin
						if (!req.sound_bus_held) begin
							case (a[14:13])
								SND_RAM0, SND_RAM1: begin
									rsp.target      = cbad_pkg::TGT_SOUNDRAM;
									rsp.local_addr  = {9'd0, a[12:0]};
									rsp.write_value = wd ? {8'h00, req.write_data[15:8]}
										: {8'h00, v8};
								end
								SND_GAP: begin
									rsp.target = cbad_pkg::TGT_NONE;
								end
								default: begin
									if (bank_page == PAGE_BANK) begin
										rsp.target      = cbad_pkg::TGT_BANK;
										rsp.write_value = {15'd0, bit_v};
									end else if (bank_page == PAGE_LOCK) begin
										rsp.lockup = 1'b1;
									end
								end
							endcase
						end
					end else if (in_io) begin
						if (wd || a[0]) begin
							rsp.target      = cbad_pkg::TGT_IO;
							rsp.local_addr  = {18'd0, a[4:1]};
							rsp.write_value = {8'h00, v8};
						end
					end else if (sub == PAGE_BUSREQ) begin
						if (wd || !a[0]) begin
							rsp.target      = cbad_pkg::TGT_BUSREQ;
							rsp.write_value = {15'd0, bit_v};
						end
					end else if (sub == PAGE_RESET) begin
						rsp.target      = cbad_pkg::TGT_RESET;
						rsp.write_value = {15'd0, bit_v};
					end else if (!quiet) begin
						rsp.lockup = 1'b1;
					end
				end
			endcase
		end
	end

endmodule

// ----- bench/tb_top.sv -----
// Self-checking testbench for the CPU bus address decoder, with its scoreboard class.
module tb_top;

	// Upper address bits 23..21 split the bus into eight areas of 2 MB.
	localparam logic [2:0] AREA_ROM_LO   = 3'd0;
	localparam logic [2:0] AREA_ROM_HI   = 3'd1;
	localparam logic [2:0] AREA_UNMAP_LO = 3'd2;
	localparam logic [2:0] AREA_UNMAP_HI = 3'd3;
	localparam logic [2:0] AREA_EXPAND   = 3'd4;
	localparam logic [2:0] AREA_SOUND_IO = 3'd5;
	localparam logic [2:0] AREA_VIDEO    = 3'd6;
	localparam logic [2:0] AREA_WORKRAM  = 3'd7;

	// Address bits 14..13 split the sound window into RAM, gap and control space.
	localparam logic [1:0] SOUND_RAM_LO = 2'd0;
	localparam logic [1:0] SOUND_RAM_HI = 2'd1;
	localparam logic [1:0] SOUND_GAP    = 2'd2;
	localparam logic [1:0] SOUND_CTRL   = 2'd3;

	localparam logic [7:0] PAGE_IO      = 8'h00;
	localparam logic [7:0] PAGE_BUSREQ  = 8'h11;
	localparam logic [7:0] PAGE_RESET   = 8'h12;
	localparam logic [7:0] PAGE_SOUND_Z = 8'h7F;

	localparam int CYCLE_LIMIT    = 200000;
	localparam int DRAIN_CYCLES   = 8;
	localparam int RANDOM_PER_PHASE = 160;

	// Golden decode of one bus access, plus the queue of results still owed by the block.
	class access_checker;
		cbad_pkg::rsp_t expected_decodes[$];
		int   failures;
		int   checked;
		int   lockups;

		function new();
			failures = 0;
			checked  = 0;
			lockups  = 0;
		endfunction

		static function logic [15:0] open_bus(logic [23:0] a, logic wd);
			logic [15:0] w;
			w = (a >= cbad_pkg::OPEN_BUS_HIGH) ? cbad_pkg::OPEN_BUS_WORD
				: (cbad_pkg::OPEN_BUS_WORD & 16'hFF00);
			if (wd)
				return w;
			return a[0] ? {8'h00, w[7:0]} : {8'h00, w[15:8]};
		endfunction

		static function logic silent_page(logic [7:0] page);
			return page == 8'h10 || page == 8'h12 || page == 8'h13 || page == 8'h20 ||
				page == 8'h30;
		endfunction

		static function cbad_pkg::rsp_t decode_access(cbad_pkg::req_t q);
			cbad_pkg::rsp_t o;
			logic [23:0] a;
			logic        wd;
			logic [15:0] openv;
			logic [15:0] ones;
			logic [15:0] rep;
			logic [7:0]  v8;
			logic [7:0]  page;
			logic [4:0]  r;
			logic [1:0]  lanes;
			logic        sel_bit;
			logic [15:0] bank_page;
			o     = '0;
			wd    = q.word_access;
			a     = q.address;
			// A word at an odd address is decoded as the aligned word.
			if (wd)
				a[0] = 1'b0;
			lanes   = wd ? 2'd3 : (a[0] ? 2'd1 : 2'd2);
			openv   = open_bus(a, wd);
			ones    = wd ? 16'hFFFF : 16'h00FF;
			v8      = q.write_data[7:0];
			rep     = {v8, v8};
			sel_bit = wd ? q.write_data[8] : q.write_data[0];
			page    = a[15:8];
			r       = a[4:0];

			if (q.kind == cbad_pkg::KIND_READ) begin
				case (a[23:21])
					AREA_ROM_LO, AREA_ROM_HI: begin
						o.target     = cbad_pkg::TGT_ROM;
						o.local_addr = a[21:0];
						o.byte_lanes = lanes;
					end
					AREA_WORKRAM: begin
						o.target     = cbad_pkg::TGT_WORKRAM;
						o.local_addr = {6'd0, a[15:0]};
						o.byte_lanes = lanes;
					end
					AREA_UNMAP_LO, AREA_UNMAP_HI: o.fill_value = openv;
					AREA_EXPAND: begin
						o.lockup     = 1'b1;
						o.fill_value = ones;
					end
					AREA_SOUND_IO: begin
						if (a <= cbad_pkg::SOUND_LAST) begin
							if (q.sound_bus_held) begin
								o.fill_value = openv;
							end else begin
								case (a[14:13])
									SOUND_RAM_LO, SOUND_RAM_HI: begin
										o.target       = cbad_pkg::TGT_SOUNDRAM;
										o.local_addr   = {9'd0, a[12:0]};
										o.device_place = wd
											? cbad_pkg::PLACE_BYTE_REP
											: cbad_pkg::PLACE_LOW_BYTE;
									end
									SOUND_GAP: o.fill_value = wd ? 16'hFFFF : 16'h0000;
									default: begin
										// Reads of the 0x7F page hang the machine.
										if (page == PAGE_SOUND_Z)
											o.lockup = 1'b1;
										o.fill_value = ones;
									end
								endcase
							end
						end else if (!wd) begin
							if (page == PAGE_IO && a <= cbad_pkg::IO_LAST) begin
								o.target       = cbad_pkg::TGT_IO;
								o.local_addr   = {18'd0, a[4:1]};
								o.device_place = cbad_pkg::PLACE_LOW_BYTE;
							end else if (page == PAGE_BUSREQ && !a[0]) begin
								o.target       = cbad_pkg::TGT_ACKSTAT;
								o.device_place = cbad_pkg::PLACE_LOW_BYTE;
								o.fill_value   = openv & 16'h00FE;
							end else if (page == PAGE_IO || page == PAGE_BUSREQ ||
								silent_page(page)) begin
								o.fill_value = openv;
							end else begin
								o.lockup     = 1'b1;
								o.fill_value = ones;
							end
						end else begin
							if (a <= cbad_pkg::IO_LAST) begin
								o.target       = cbad_pkg::TGT_IO;
								o.local_addr   = {18'd0, a[4:1]};
								o.device_place = cbad_pkg::PLACE_BYTE_REP;
							end else if (page == PAGE_BUSREQ) begin
								o.target       = cbad_pkg::TGT_ACKSTAT;
								o.device_place = cbad_pkg::PLACE_LOW_TO_HIGH;
								o.fill_value   = openv & 16'hFEFF;
							end else if (silent_page(page)) begin
								o.fill_value = openv;
							end else begin
								o.lockup     = 1'b1;
								o.fill_value = ones;
							end
						end
					end
					default: begin
						if ((a & cbad_pkg::VDP_MASK) != cbad_pkg::VDP_MATCH) begin
							o.lockup     = 1'b1;
							o.fill_value = ones;
						end else if (r < 5'h10) begin
							o.target = (r < 5'h04) ? cbad_pkg::TGT_VDATA :
								((r < 5'h08) ? cbad_pkg::TGT_VCTRL
								: cbad_pkg::TGT_VCOUNTER);
							o.device_place = wd ? cbad_pkg::PLACE_WORD :
								(r[0] ? cbad_pkg::PLACE_LOW_BYTE
								: cbad_pkg::PLACE_HIGH_TO_LOW);
							if (o.target == cbad_pkg::TGT_VCTRL)
								o.fill_value = wd ? (openv & 16'hFC00) :
									(a[0] ? 16'h0000 : (openv & 16'h00FC));
						end else if (r < 5'h18) begin
							o.lockup     = 1'b1;
							o.fill_value = ones;
						end else begin
							o.fill_value = openv;
						end
					end
				endcase
			end else begin
				case (a[23:21])
					AREA_ROM_LO, AREA_ROM_HI, AREA_UNMAP_LO, AREA_UNMAP_HI: ;
					AREA_EXPAND: o.lockup = 1'b1;
					AREA_WORKRAM: begin
						o.target      = cbad_pkg::TGT_WORKRAM;
						o.local_addr  = {6'd0, a[15:0]};
						o.byte_lanes  = lanes;
						o.write_value = wd ? q.write_data : rep;
					end
					AREA_VIDEO: begin
						if ((a & cbad_pkg::VDP_MASK) != cbad_pkg::VDP_MATCH) begin
							o.lockup = 1'b1;
						end else if (r < 5'h08) begin
							o.target      = (r < 5'h04) ? cbad_pkg::TGT_VDATA
								: cbad_pkg::TGT_VCTRL;
							o.write_value = wd ? q.write_data : rep;
						end else if (r < 5'h10) begin
							o.lockup = 1'b1;
						end
					end
					default: begin
						if (a <= cbad_pkg::SOUND_LAST) begin
							if (!q.sound_bus_held) begin
								// Byte and word paths look at different page masks.
								bank_page = a[15:0] & (wd ? 16'h7F00 : 16'hFF00);
								case (a[14:13])
									SOUND_RAM_LO, SOUND_RAM_HI: begin
										o.target      = cbad_pkg::TGT_SOUNDRAM;
										o.local_addr  = {9'd0, a[12:0]};
										o.write_value = wd ? {8'd0, q.write_data[15:8]} :
											{8'd0, v8};
									end
									SOUND_GAP: ;
									default: begin
										if (bank_page == 16'h6000) begin
											o.target      = cbad_pkg::TGT_BANK;
											o.write_value = {15'd0, sel_bit};
										end else if (bank_page == 16'h7F00) begin
											o.lockup = 1'b1;
										end
									end
								endcase
							end
						end else if (a <= cbad_pkg::IO_LAST) begin
							if (wd || a[0]) begin
								o.target      = cbad_pkg::TGT_IO;
								o.local_addr  = {18'd0, a[4:1]};
								o.write_value = {8'd0, v8};
							end
						end else if (page == PAGE_BUSREQ) begin
							if (wd || !a[0]) begin
								o.target      = cbad_pkg::TGT_BUSREQ;
								o.write_value = {15'd0, sel_bit};
							end
						end else if (page == PAGE_RESET) begin
							o.target      = cbad_pkg::TGT_RESET;
							o.write_value = {15'd0, sel_bit};
						end else if (!silent_page(page)) begin
							o.lockup = 1'b1;
						end
					end
				endcase
			end
			return o;
		endfunction

		function void note_access(cbad_pkg::req_t q);
			expected_decodes.push_back(decode_access(q));
		endfunction

		function void compare_field(string name, logic [31:0] want, logic [31:0] got);
			if (want !== got) begin
				$error("field %s: expected 0x%0h, got 0x%0h", name, want, got);
				failures++;
			end
		endfunction

		function void check_decode(cbad_pkg::rsp_t got);
			cbad_pkg::rsp_t want;
			if (expected_decodes.size() == 0) begin
				$error("decode result arrived with no transaction outstanding");
				failures++;
				return;
			end
			want = expected_decodes.pop_front();
			checked++;
			if (want.lockup)
				lockups++;
			compare_field("target", 32'(want.target), 32'(got.target));
			compare_field("local_addr", 32'(want.local_addr), 32'(got.local_addr));
			compare_field("byte_lanes", 32'(want.byte_lanes), 32'(got.byte_lanes));
			compare_field("device_place", 32'(want.device_place), 32'(got.device_place));
			compare_field("fill_value", 32'(want.fill_value), 32'(got.fill_value));
			compare_field("write_value", 32'(want.write_value), 32'(got.write_value));
			compare_field("lockup", 32'(want.lockup), 32'(got.lockup));
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	cbad_pkg::req_t req = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	cbad_pkg::rsp_t rsp;

	// Idle and stall odds in percent; the stimulus changes them phase by phase.
	int sender_idle_pct = 0;
	int receiver_stall_pct = 0;
	int cycle_count = 0;
	int sent_count = 0;

	access_checker board = new();

	cpu_bus_address_decoder u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// The receiver decides its stall at every falling edge, so the value is settled
	// well before the rising edge that may complete a transaction.
	always @(negedge clk) begin
		rsp_stall <= ($urandom_range(99) < receiver_stall_pct);
	end

	// Both channels are sampled at the rising edge. The block updates its outputs
	// with nonblocking assignments, so the values seen here are the ones that were
	// present just before the edge, which is what decides a handshake.
	always @(posedge clk) begin
		if (arst_n) begin
			if (req_valid && !req_stall)
				board.note_access(req);
			if (rsp_valid && !rsp_stall)
				board.check_decode(rsp);
		end
	end

	// Watchdog: a hung handshake ends the run as a failure.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	function automatic cbad_pkg::req_t make_access(logic kind, logic wd, logic [23:0] addr,
		logic [15:0] data, logic held);
		cbad_pkg::req_t q;
		q.kind           = kind;
		q.word_access    = wd;
		q.address        = addr;
		q.write_data     = data;
		q.sound_bus_held = held;
		return q;
	endfunction

	// Random transactions are steered toward the areas where the decode has
	// corner cases: the sound window pages, the I/O and control pages that mirror
	// up to 0xBFFFFF, and the video port window with its address holes.
	function automatic cbad_pkg::req_t random_access();
		cbad_pkg::req_t q;
		logic [15:0] low;
		logic [7:0]  top;
		logic [7:0]  page;
		q.kind           = 1'($urandom_range(1));
		q.word_access    = 1'($urandom_range(1));
		q.write_data     = 16'($urandom);
		q.sound_bus_held = ($urandom_range(3) == 0);
		case ($urandom_range(9))
			0: q.address = 24'($urandom);
			1: q.address = {2'b00, 22'($urandom)};
			2: q.address = {3'b111, 21'($urandom)};
			3, 4: begin
				low = 16'($urandom);
				if ($urandom_range(1))
					low[14:8] = $urandom_range(1) ? 7'h60 : 7'h7F;
				q.address = {8'hA0, low};
			end
			5, 6: begin
				top = ($urandom_range(3) == 0) ? 8'($urandom_range(8'hBF, 8'hA2)) : 8'hA1;
				case ($urandom_range(7))
					0: page = PAGE_IO;
					1: page = PAGE_BUSREQ;
					2: page = PAGE_RESET;
					3: page = 8'h13;
					4: page = 8'h10;
					5: page = 8'h20;
					6: page = 8'h30;
					default: page = 8'($urandom);
				endcase
				q.address = {top, page,
					$urandom_range(1) ? 8'($urandom_range(8'h3F)) : 8'($urandom)};
			end
			7, 8: q.address = (24'($urandom) & ~cbad_pkg::VDP_MASK) | cbad_pkg::VDP_MATCH;
			default: q.address = {3'b110, 21'($urandom)};
		endcase
		return q;
	endfunction

	// Presents one transaction at a falling edge and holds it until it is taken.
	task automatic send_access(input cbad_pkg::req_t q);
		while ($urandom_range(99) < sender_idle_pct) begin
			req_valid <= 1'b0;
			@(negedge clk);
		end
		req_valid <= 1'b1;
		req       <= q;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		sent_count++;
		@(negedge clk);
	endtask

	task automatic run_random(input int count);
		repeat (count)
			send_access(random_access());
	endtask

	initial begin
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed transactions, no idling: area extremes, each target, and the odd
		// width-dependent behaviors of the sound, I/O and video windows.
		send_access(make_access(cbad_pkg::KIND_READ, 1'b0, 24'h000000, 16'h0000, 1'b0));
		send_access(make_access(cbad_pkg::KIND_WRITE, 1'b1, 24'hFFFFFF, 16'hFFFF, 1'b1));
		send_access(make_access(cbad_pkg::KIND_READ, 1'b1, 24'hFF0001, 16'h0000, 1'b0));
		send_access(make_access(cbad_pkg::KIND_WRITE, 1'b0, 24'h000101, 16'hFFFF, 1'b0));
		send_access(make_access(cbad_pkg::KIND_READ, 1'b1, 24'h400000, 16'h0000, 1'b0));
		send_access(make_access(cbad_pkg::KIND_READ, 1'b0, 24'h800001, 16'h0000, 1'b0));
		send_access(make_access(cbad_pkg::KIND_READ, 1'b1, 24'hA00000, 16'h0000, 1'b1));
		send_access(make_access(cbad_pkg::KIND_WRITE, 1'b0, 24'hA01FFF, 16'h01A5, 1'b0));
		send_access(make_access(cbad_pkg::KIND_READ, 1'b0, 24'hA04000, 16'h0000, 1'b0));
		send_access(make_access(cbad_pkg::KIND_READ, 1'b1, 24'hA04000, 16'h0000, 1'b0));
		send_access(make_access(cbad_pkg::KIND_READ, 1'b0, 24'hA07F00, 16'h0000, 1'b0));
		send_access(make_access(cbad_pkg::KIND_WRITE, 1'b0, 24'hA0FF00, 16'h00FF, 1'b0));
		send_access(make_access(cbad_pkg::KIND_WRITE, 1'b1, 24'hA0FF00, 16'hFFFF, 1'b0));
		send_access(make_access(cbad_pkg::KIND_WRITE, 1'b0, 24'hA06000, 16'h0001, 1'b0));
		send_access(make_access(cbad_pkg::KIND_WRITE, 1'b1, 24'hA0E000, 16'h0100, 1'b0));
		send_access(make_access(cbad_pkg::KIND_WRITE, 1'b0, 24'hA10003, 16'h5A5A, 1'b0));
		send_access(make_access(cbad_pkg::KIND_WRITE, 1'b0, 24'hA10002, 16'h5A5A, 1'b0));
		send_access(make_access(cbad_pkg::KIND_READ, 1'b0, 24'hA10020, 16'h0000, 1'b0));
		send_access(make_access(cbad_pkg::KIND_READ, 1'b1, 24'hA10020, 16'h0000, 1'b0));
		send_access(make_access(cbad_pkg::KIND_READ, 1'b0, 24'hA11100, 16'h0000, 1'b0));
		send_access(make_access(cbad_pkg::KIND_READ, 1'b1, 24'hBF1100, 16'h0000, 1'b0));
		send_access(make_access(cbad_pkg::KIND_WRITE, 1'b0, 24'hA11101, 16'h0001, 1'b0));
		send_access(make_access(cbad_pkg::KIND_WRITE, 1'b1, 24'hA11200, 16'h0100, 1'b0));
		send_access(make_access(cbad_pkg::KIND_READ, 1'b0, 24'hC00004, 16'h0000, 1'b0));
		send_access(make_access(cbad_pkg::KIND_READ, 1'b0, 24'hC00011, 16'h0000, 1'b0));
		send_access(make_access(cbad_pkg::KIND_WRITE, 1'b0, 24'hC00008, 16'h00C3, 1'b0));

		// Random traffic in four mixes of sender idling and receiver stalling.
		run_random(RANDOM_PER_PHASE);
		sender_idle_pct = 47;
		run_random(RANDOM_PER_PHASE);
		sender_idle_pct    = 0;
		receiver_stall_pct = 47;
		run_random(RANDOM_PER_PHASE);
		sender_idle_pct    = 34;
		receiver_stall_pct = 34;
		run_random(RANDOM_PER_PHASE);
		req_valid <= 1'b0;

		// Drain: every accepted transaction must come back, then a quiet drain period
		// catches any stray extra result.
		while (board.expected_decodes.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d bus transactions across four idle/stall mixes; %0d decodes checked.",
			sent_count, board.checked);
		$display("Decodes that raised lockup: %0d; field mismatches and strays: %0d.",
			board.lockups, board.failures);
		if (board.failures == 0 && board.expected_decodes.size() == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
